// ----- rtl/wsh_pkg.sv -----
// Shared types and constants for the water-surface height block.
// Used by every module of the block but the checker; depends on nothing.
package wsh_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_LEVEL = 2'd0;
  localparam logic [1:0] REG_AMP   = 2'd1;
  localparam logic [1:0] REG_RATE  = 2'd2;

  // Phase reduction constants
  localparam logic [34:0] TWO_PI_Q32     = 35'd26986075409;
  localparam logic [17:0] TWO_PI_LO      = TWO_PI_Q32[17:0];
  localparam logic [16:0] TWO_PI_HI      = TWO_PI_Q32[34:18];
  // 2^58 / TWO_PI_Q32, rounded: quotient estimate from the phase top bits
  localparam logic [23:0] RECIP_TWO_PI   = 24'd10680707;
  localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
  localparam logic [23:0] QUARTER_TURN   = 24'h400000;

  // Quarter-wave sine coefficients, Q.30
  localparam logic [30:0] SIN_A1 = 31'd1686629713;
  localparam logic [30:0] SIN_A3 = 31'd693598669;
  localparam logic [30:0] SIN_A5 = 31'd85569306;
  localparam logic [30:0] SIN_A7 = 31'd5026995;
  localparam logic [17:0] SIN_A9 = 18'd172272;

  localparam logic signed [21:0] Z_MIN = -22'sd524288;
  localparam logic signed [21:0] Z_MAX = 22'sd524287;

  // Turn angles of one vertex, handed from front to back
  typedef struct packed {
    logic [23:0] a_cos;
    logic [23:0] a_sin;
  } angles_t;

endpackage

// ----- rtl/wave_surface_height.sv -----
// Water-surface height: z = level + amplitude * sin(rate*(x+t)) * cos(rate*(y+t)).
// Throughput one vertex per cycle while the output is not stalled; the angle queue
// of QUEUE_DEPTH entries holds items from the front pipeline while the back
// pipeline is stalled by the output.
// Reset (synchronous, rst high) clears config registers, queue and all valids.
// Depends on wsh_pkg, wsh_front, wsh_queue, wsh_sine, wsh_back.
module wave_surface_height #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // pos_x[19:0], pos_y[39:20], now[63:40]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // height_z[19:0], zero[23:20]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  logic signed [19:0] water_level;
  logic [15:0]        wave_amplitude;
  logic [15:0]        wave_rate;

  logic               front_valid;
  wsh_pkg::angles_t   front_angles;
  logic               pop;
  logic               avail;
  wsh_pkg::angles_t   queue_angles;
  logic signed [19:0] height_z;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      water_level    <= '0;
      wave_amplitude <= '0;
      wave_rate      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        wsh_pkg::REG_LEVEL: water_level    <= cfg_data;
        wsh_pkg::REG_AMP:   wave_amplitude <= cfg_data[15:0];
        wsh_pkg::REG_RATE:  wave_rate      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  wsh_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .pos_x      (s_axis_tdata[19:0]),
    .pos_y      (s_axis_tdata[39:20]),
    .now        (s_axis_tdata[63:40]),
    .rate       (wave_rate),
    .pop        (pop),
    .out_valid  (front_valid),
    .out_angles (front_angles)
  );

  wsh_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (front_valid),
    .wdata (front_angles),
    .pop   (pop),
    .avail (avail),
    .rdata (queue_angles)
  );

  wsh_back u_back (
    .clk       (clk),
    .rst       (rst),
    .avail     (avail),
    .angles    (queue_angles),
    .pop       (pop),
    .amp       (wave_amplitude),
    .level     (water_level),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .height_z  (height_z)
  );

  assign m_axis_tdata = {4'b0000, height_z};

endmodule

// ----- rtl/wsh_front.sv -----
// Front part: accepts vertices and reduces both phases to 24-bit turn angles.
// Depends on wsh_pkg; hands angles to the queue under a credit count.
module wsh_front #(
  parameter int DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [19:0]    pos_x,
  input  logic signed [19:0]    pos_y,
  input  logic [23:0]           now,
  input  logic [15:0]           rate,
  input  logic                  pop,
  output logic                  out_valid,
  output wsh_pkg::angles_t      out_angles
);

  localparam int CW  = $clog2(DEPTH + 1);
  localparam int LAT = 7;

  logic [CW-1:0]      reserved;
  logic               accept;
  logic [LAT-1:0]     vld;

  logic signed [25:0] s    [2];
  logic signed [41:0] p    [2];
  logic signed [41:0] p3   [2];
  logic signed [41:0] p4   [2];
  logic signed [22:0] q    [2];
  logic signed [41:0] plo  [2];
  logic signed [40:0] phi  [2];
  logic signed [36:0] r0   [2];
  logic [34:0]        r    [2];
  logic [23:0]        a    [2];

  logic signed [66:0] qprod [2];
  logic signed [59:0] diff  [2];
  logic signed [36:0] rfix  [2];
  logic [56:0]        aprod [2];
  logic signed [36:0] c37;

  // Credit: every item in flight or queued holds one queue slot
  assign accept   = in_valid && in_ready;
  assign in_ready = reserved < CW'(DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      reserved <= '0;
      vld      <= '0;
    end else begin
      reserved <= reserved + CW'(accept) - CW'(pop);
      vld      <= {vld[LAT-2:0], accept};
    end
  end

  assign c37 = $signed({2'b00, wsh_pkg::TWO_PI_Q32});

  // Quotient estimate, remainder, correction and turn conversion
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      qprod[i] = (p[i] >>> 6) * $signed({1'b0, wsh_pkg::RECIP_TWO_PI});
      diff[i]  = $signed({{4{p4[i][41]}}, p4[i], 14'b0})
               - $signed({phi[i][40], phi[i], 18'b0})
               - $signed({{18{plo[i][41]}}, plo[i]});
      if (r0[i] < 0) begin
        rfix[i] = r0[i] + c37;
      end else if (r0[i] >= c37) begin
        rfix[i] = r0[i] - c37;
      end else begin
        rfix[i] = r0[i];
      end
      aprod[i] = 57'(r[i][34:8]) * 57'(wsh_pkg::INV_TWO_PI_Q32);
    end
  end

  // Advance both lanes every cycle
  always_ff @(posedge clk) begin
    s[0] <= $signed({{6{pos_x[19]}}, pos_x}) + $signed({2'b00, now});
    s[1] <= $signed({{6{pos_y[19]}}, pos_y}) + $signed({2'b00, now});
    for (int i = 0; i < 2; i++) begin
      p[i]   <= 42'($signed({1'b0, rate})) * 42'(s[i]);
      q[i]   <= qprod[i][60:38];
      p3[i]  <= p[i];
      plo[i] <= q[i] * $signed({1'b0, wsh_pkg::TWO_PI_LO});
      phi[i] <= q[i] * $signed({1'b0, wsh_pkg::TWO_PI_HI});
      p4[i]  <= p3[i];
      r0[i]  <= diff[i][36:0];
      r[i]   <= rfix[i][34:0];
      a[i]   <= aprod[i][55:32] + ((i == 1) ? wsh_pkg::QUARTER_TURN : 24'd0);
    end
  end

  assign out_valid        = vld[LAT-1];
  assign out_angles.a_sin = a[0];
  assign out_angles.a_cos = a[1];

endmodule

// ----- rtl/wsh_queue.sv -----
// Angle queue between front and back parts, with registered read data.
// Depends on wsh_pkg for the entry type.
module wsh_queue #(
  parameter int DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  wsh_pkg::angles_t wdata,
  input  logic             pop,
  output logic             avail,
  output wsh_pkg::angles_t rdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  wsh_pkg::angles_t mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [CW-1:0]    count;

  assign avail = count != '0;

  // Track pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + AW'(1);
      end
      if (pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + AW'(1);
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

  // Write and read the storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
    if (pop) begin
      rdata <= mem[rptr];
    end
  end

endmodule

// ----- rtl/wsh_sine.sv -----
// One sine lane: quarter-wave polynomial over a 24-bit turn angle to Q1.15.
// Depends on wsh_pkg for coefficients; six stages that advance on en.
module wsh_sine (
  input  logic               clk,
  input  logic               en,
  input  logic [23:0]        angle,
  output logic signed [15:0] value
);

  logic [1:0]  quad;
  logic [30:0] u_in;
  logic [61:0] uu;

  logic [30:0] u   [5];
  logic [30:0] u2  [5];
  logic        neg [5];
  logic [30:0] t1, t2, t3, t4;

  logic [48:0] m9;
  logic [61:0] m7, m5, m3, mv;
  logic [31:0] vsum;
  logic [16:0] vr;
  logic [14:0] vc;

  // Fold the angle into the first quadrant, form the Horner products, round and clamp
  always_comb begin
    quad = angle[23:22];
    if (quad[0]) begin
      u_in = 31'h40000000 - {1'b0, angle[21:0], 8'b0};
    end else begin
      u_in = {1'b0, angle[21:0], 8'b0};
    end
    uu   = 62'(u_in) * 62'(u_in);
    m9   = 49'(wsh_pkg::SIN_A9) * 49'(u2[0]);
    m7   = 62'(t1) * 62'(u2[1]);
    m5   = 62'(t2) * 62'(u2[2]);
    m3   = 62'(t3) * 62'(u2[3]);
    mv   = 62'(t4) * 62'(u[4]);
    vsum = mv[61:30] + 32'h4000;
    vr   = vsum[31:15];
    vc   = (vr > 17'd32767) ? 15'h7fff : vr[14:0];
  end

  // Horner steps, one per stage
  always_ff @(posedge clk) begin
    if (en) begin
      u[0]   <= u_in;
      u2[0]  <= uu[60:30];
      neg[0] <= quad[1];
      for (int k = 1; k < 5; k++) begin
        u[k]   <= u[k-1];
        u2[k]  <= u2[k-1];
        neg[k] <= neg[k-1];
      end
      t1 <= wsh_pkg::SIN_A7 - 31'(m9[48:30]);
      t2 <= wsh_pkg::SIN_A5 - 31'(m7[61:30]);
      t3 <= wsh_pkg::SIN_A3 - 31'(m5[61:30]);
      t4 <= wsh_pkg::SIN_A1 - 31'(m3[61:30]);
      value <= neg[4] ? -$signed({1'b0, vc}) : $signed({1'b0, vc});
    end
  end

endmodule

// ----- rtl/wsh_back.sv -----
// Back part: pops angles, evaluates sin and cos, scales and adds the level.
// Depends on wsh_pkg and wsh_sine; the whole pipeline holds while the output stalls.
module wsh_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               avail,
  input  wsh_pkg::angles_t   angles,
  output logic               pop,
  input  logic [15:0]        amp,
  input  logic signed [19:0] level,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [19:0] height_z
);

  localparam int LAT = 10;

  logic               en;
  logic [LAT-1:0]     vld;
  logic signed [15:0] sv, cv;
  logic signed [31:0] sc;
  logic signed [48:0] m;
  logic signed [48:0] mr;
  logic signed [21:0] zsum;
  logic signed [19:0] zsat;

  assign en        = !out_valid || out_ready;
  assign pop       = en && avail;
  assign out_valid = vld[LAT-1];

  // Advance request valids with the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], pop};
    end
  end

  wsh_sine u_sin (.clk(clk), .en(en), .angle(angles.a_sin), .value(sv));
  wsh_sine u_cos (.clk(clk), .en(en), .angle(angles.a_cos), .value(cv));

  // Round to Q.10, add level, saturate
  always_comb begin
    mr   = m + 49'sd134217728;
    zsum = $signed({{2{level[19]}}, level}) + $signed({mr[48], mr[48:28]});
    if (zsum < wsh_pkg::Z_MIN) begin
      zsat = wsh_pkg::Z_MIN[19:0];
    end else if (zsum > wsh_pkg::Z_MAX) begin
      zsat = wsh_pkg::Z_MAX[19:0];
    end else begin
      zsat = zsum[19:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc       <= sv * cv;
      m        <= $signed({1'b0, amp}) * sc;
      height_z <= zsat;
    end
  end

endmodule

// ----- rtl/wsh_checker.sv -----
// Port-level checks for the water-surface height block, bound to the top level.
// Depends only on the top-level ports.
module wsh_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  // Hold a stalled result request
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result request dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result data changed while stalled");

  // Clear results on reset
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // Pad bits above the height stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[23:20] == 4'b0000)
    else $error("nonzero pad bits in result");

  // Accept input right after reset: all queue credits are free
  a_ready_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> s_axis_tready)
    else $error("input not ready after reset");

endmodule

bind wave_surface_height wsh_checker u_wsh_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ----- tb/sv/tb.sv -----
// Testbench for wave_surface_height: drives vertex requests, predicts each
// surface height in fixed point and checks the result stream. Depends on wsh_pkg.
module tb;

  localparam int LATENCY = 17;
  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // pos_x[19:0], pos_y[39:20], now[63:40]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // height_z[19:0], zero[23:20]
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [19:0] cfg_data;

  typedef struct packed {
    logic [23:0] now;
    logic [19:0] pos_y;
    logic [19:0] pos_x;
  } vertex_t;

  // Configuration copy
  logic signed [19:0] level_q;
  logic [15:0]        amp_q;
  logic [15:0]        rate_q;

  vertex_t     vertex_q[$];
  logic [19:0] height_q[$];
  int          errors;
  int          idle_cycles;
  int          gap_left;
  int          burst_left;
  bit          stimulus_done;

  wave_surface_height dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Phase turned into a 24-bit fraction of a turn
  function automatic logic [23:0] turn_of(input logic signed [25:0] s);
    longint p;
    longint r;
    logic [63:0] prod;
    p = longint'(rate_q) * longint'(s);
    r = (p * 64'sd16384) % 64'sd26986075409;
    if (r < 0) r = r + 64'sd26986075409;
    prod = (64'(r) >> 8) * 64'd683565276;
    return prod[55:32];
  endfunction

  // Quarter-wave polynomial sine, Q1.15
  function automatic longint sine_q15(input logic [23:0] a);
    logic [1:0]  quad;
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] t;
    logic [63:0] v;
    quad = a[23:22];
    u = 64'(a[21:0]) << 8;
    if (quad[0]) u = (64'd1 << 30) - u;
    u2 = (u * u) >> 30;
    t = 64'd5026995 - ((64'd172272 * u2) >> 30);
    t = 64'd85569306 - ((t * u2) >> 30);
    t = 64'd693598669 - ((t * u2) >> 30);
    t = 64'd1686629713 - ((t * u2) >> 30);
    v = (t * u) >> 30;
    v = (v + (64'd1 << 14)) >> 15;
    if (v > 64'd32767) v = 64'd32767;
    return quad[1] ? -longint'(v) : longint'(v);
  endfunction

  function automatic logic [19:0] surface_height(input vertex_t vx);
    longint sv;
    longint cv;
    longint m;
    longint d;
    longint z;
    logic signed [25:0] sx;
    logic signed [25:0] sy;
    sx = 26'($signed(vx.pos_x)) + 26'(vx.now);
    sy = 26'($signed(vx.pos_y)) + 26'(vx.now);
    sv = sine_q15(turn_of(sx));
    cv = sine_q15(turn_of(sy) + wsh_pkg::QUARTER_TURN);
    m = longint'(amp_q) * (sv * cv) + (64'sd1 <<< 27);
    d = m >>> 28;
    z = longint'(level_q) + d;
    if (z < -524288) z = -524288;
    if (z > 524287) z = 524287;
    return z[19:0];
  endfunction

  // Drive requests in bursts with random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      gap_left <= 0;
      burst_left <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) height_q.push_back(surface_height(s_axis_tdata));
      if (gap_left > 0 || vertex_q.size() == 0) begin
        s_axis_tvalid <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= vertex_q.pop_front();
        if (burst_left == 0) begin
          burst_left <= $urandom_range(40, 1);
          gap_left <= ($urandom_range(2) == 0) ? 0 : $urandom_range(6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Stall the output on its own pattern
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else if ($time / 3000 % 3 == 0) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(3) != 0);
  end

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (height_q.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %h", $time, m_axis_tdata);
        errors++;
      end else begin
        if (m_axis_tdata[19:0] !== height_q[0] || m_axis_tdata[23:20] !== 4'd0) begin
          $display("%0t height_z mismatch: expected %h, actual %h",
                   $time, height_q[0], m_axis_tdata);
          errors++;
        end
        void'(height_q.pop_front());
      end
    end
  end

  // Watchdog on cycles without any accepted request or result
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || stimulus_done)
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT && (height_q.size() != 0 || vertex_q.size() != 0
          || s_axis_tvalid)) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [19:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      wsh_pkg::REG_LEVEL: level_q = val;
      wsh_pkg::REG_AMP:   amp_q = val[15:0];
      wsh_pkg::REG_RATE:  rate_q = val[15:0];
      default: ;
    endcase
  endtask

  task automatic drain;
    int guard;
    guard = 0;
    while ((vertex_q.size() != 0 || s_axis_tvalid || height_q.size() != 0)
           && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic vertex_t rand_vertex();
    vertex_t vx;
    vx.pos_x = 20'($urandom);
    vx.pos_y = 20'($urandom);
    vx.now = 24'($urandom);
    // Put about one vertex in four near the origin and early in time
    if ($urandom_range(3) == 0) begin
      vx.pos_x = 20'($signed($urandom_range(8000)) - 4000);
      vx.pos_y = 20'($signed($urandom_range(8000)) - 4000);
      vx.now = 24'($urandom_range(20000));
    end
    return vx;
  endfunction

  initial begin
    vertex_t vx;
    logic [19:0] edges20[4];
    logic [23:0] edges24[3];
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = wsh_pkg::REG_LEVEL;
    cfg_data = '0;
    errors = 0;
    stimulus_done = 1'b0;
    level_q = '0;
    amp_q = '0;
    rate_q = '0;
    edges20 = '{20'h80000, 20'h7FFFF, 20'h00000, 20'hFFFFF};
    edges24 = '{24'h000000, 24'hFFFFFF, 24'h000400};
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: zero rate and amplitude leave the rest level
    for (int i = 0; i < 4; i++) begin
      vx.pos_x = edges20[i]; vx.pos_y = edges20[3 - i]; vx.now = edges24[i % 3];
      vertex_q.push_back(vx);
    end
    drain();

    // Directed extremes with large rate and amplitude, saturation both ways
    write_reg(wsh_pkg::REG_AMP, 20'h0FFFF);
    write_reg(wsh_pkg::REG_RATE, 20'h0FFFF);
    write_reg(wsh_pkg::REG_LEVEL, 20'h7FFFF);
    for (int i = 0; i < 12; i++) begin
      vx.pos_x = edges20[i % 4]; vx.pos_y = edges20[(i / 4) % 4]; vx.now = edges24[i % 3];
      vertex_q.push_back(vx);
    end
    drain();
    write_reg(wsh_pkg::REG_LEVEL, 20'h80000);
    // Out-of-range index is ignored by the block
    write_reg(2'd3, 20'h12345);
    for (int i = 0; i < 8; i++) vertex_q.push_back(rand_vertex());
    drain();

    // Random phases over several settings
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(wsh_pkg::REG_LEVEL, (ph == 0) ? 20'h0 : 20'($urandom));
      write_reg(wsh_pkg::REG_AMP, (ph == 1) ? 20'h0 : (ph == 2) ? 20'hFFFFF : 20'($urandom));
      write_reg(wsh_pkg::REG_RATE, (ph == 3) ? 20'h0 : (ph == 4) ? 20'h0FFFF
                : 20'($urandom_range(2048)));
      for (int i = 0; i < 135; i++) vertex_q.push_back(rand_vertex());
      drain();
    end
    stimulus_done = 1'b1;

    if (errors == 0 && height_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ----- files.f -----
rtl/wsh_pkg.sv
rtl/wsh_front.sv
rtl/wsh_queue.sv
rtl/wsh_sine.sv
rtl/wsh_back.sv
rtl/wave_surface_height.sv
rtl/wsh_checker.sv
tb/sv/tb.sv
